// ===== sv/agu_pkg.sv =====
`timescale 1ns / 1ps
package agu_pkg;
	// register indexes
	localparam logic [0:0] RegLearningRate = 1'b0;
	localparam logic [0:0] RegEpsilon      = 1'b1;

	localparam logic [15:0] LrReset  = 16'd655;
	localparam logic [15:0] EpsReset = 16'd1;

	// root of a 48-bit radicand: 24 result bits, 26-bit divisor
	localparam int SqrtBits   = 24;
	localparam int SqrtSteps  = 8;   // root bits resolved per stage
	localparam int SqrtStages = SqrtBits / SqrtSteps;
	localparam int DivBits    = 47;  // quotient bits of lr * |g| / d
	localparam int DivSteps   = 7;   // quotient bits per stage
	localparam int DivStages  = (DivBits + DivSteps - 1) / DivSteps;

	typedef struct packed {
		logic signed [31:0] gradient;
		logic [31:0]        accum_in;
		logic signed [31:0] weight_in;
		logic               is_last;
	} in_t;

	typedef struct packed {
		logic [31:0]        accum_out;
		logic signed [31:0] weight_out;
		logic               last_out;
	} out_t;

	// fields that ride along with the arithmetic
	typedef struct packed {
		logic               neg;
		logic [46:0]        num;
		logic signed [31:0] weight;
		logic [31:0]        accum;
		logic               last;
	} side_t;
endpackage

// ===== sv/agu_sqrt.sv =====
`timescale 1ns / 1ps
// pipelined restoring square root, SqrtSteps root bits per stage
module agu_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [31:0]         radicand,
	input  agu_pkg::side_t      in_side,
	output logic                out_valid,
	output logic [24:0]         root,
	output agu_pkg::side_t      out_side
);
	localparam int NS = agu_pkg::SqrtStages;
	localparam int NB = agu_pkg::SqrtSteps;

	logic                 v_s  [NS+1];
	logic [47:0]          x_s  [NS+1];  // radicand still to consume
	logic [25:0]          r_s  [NS+1];  // remainder
	logic [23:0]          q_s  [NS+1];  // root so far
	agu_pkg::side_t       sd_s [NS+1];

	assign v_s[0]  = in_valid;
	assign x_s[0]  = {radicand, 16'h0000};
	assign r_s[0]  = '0;
	assign q_s[0]  = '0;
	assign sd_s[0] = in_side;

	for (genvar k = 0; k < NS; k++) begin : g_st
		logic [47:0] x_c;
		logic [25:0] r_c;
		logic [23:0] q_c;
		logic [27:0] t;
		// one root bit per step, remainder bounded by 2q+1
		always_comb begin
			x_c = x_s[k];
			r_c = r_s[k];
			q_c = q_s[k];
			t   = '0;
			for (int i = 0; i < NB; i++) begin
				t = {r_c, x_c[47:46]} - {2'b00, q_c, 2'b01};
				x_c = {x_c[45:0], 2'b00};
				if (!t[27]) begin
					r_c = t[25:0];
					q_c = {q_c[22:0], 1'b1};
				end else begin
					r_c = {r_c[23:0], t[1:0] + 2'b01};
					q_c = {q_c[22:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			x_s[k+1]  <= x_c;
			r_s[k+1]  <= r_c;
			q_s[k+1]  <= q_c;
			sd_s[k+1] <= sd_s[k];
		end
	end

	assign out_valid = v_s[NS];
	assign root      = {1'b0, q_s[NS]};
	assign out_side  = sd_s[NS];
endmodule

// ===== sv/agu_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, DivSteps quotient bits per stage
module agu_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [25:0]         divisor,
	input  agu_pkg::side_t      in_side,
	output logic                out_valid,
	output logic [46:0]         quotient,
	output agu_pkg::side_t      out_side
);
	localparam int NS = agu_pkg::DivStages;
	localparam int NB = agu_pkg::DivSteps;
	localparam int QB = agu_pkg::DivBits;

	logic             v_s  [NS+1];
	logic [25:0]      d_s  [NS+1];
	logic [25:0]      r_s  [NS+1];
	logic [QB-1:0]    n_s  [NS+1];  // dividend shifting out, quotient shifting in
	logic [6:0]       c_s  [NS+1];  // bits left
	agu_pkg::side_t   sd_s [NS+1];

	assign v_s[0]  = in_valid;
	assign d_s[0]  = divisor;
	assign r_s[0]  = '0;
	assign n_s[0]  = in_side.num;
	assign c_s[0]  = 7'(QB);
	assign sd_s[0] = in_side;

	for (genvar k = 0; k < NS; k++) begin : g_st
		logic [25:0]   r_c;
		logic [QB-1:0] n_c;
		logic [6:0]    c_c;
		logic [26:0]   t;
		always_comb begin
			r_c = r_s[k];
			n_c = n_s[k];
			c_c = c_s[k];
			t   = '0;
			for (int i = 0; i < NB; i++) begin
				if (c_c != 7'd0) begin
					t = {r_c, n_c[QB-1]} - {1'b0, d_s[k]};
					if (!t[26]) begin
						r_c = t[25:0];
						n_c = {n_c[QB-2:0], 1'b1};
					end else begin
						r_c = {r_c[24:0], n_c[QB-1]};
						n_c = {n_c[QB-2:0], 1'b0};
					end
					c_c = c_c - 7'd1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			d_s[k+1]  <= d_s[k];
			r_s[k+1]  <= r_c;
			n_s[k+1]  <= n_c;
			c_s[k+1]  <= c_c;
			sd_s[k+1] <= sd_s[k];
		end
	end

	assign out_valid = v_s[NS];
	assign quotient  = n_s[NS];
	assign out_side  = sd_s[NS];
endmodule

// ===== sv/adagrad_weight_update.sv =====
`timescale 1ns / 1ps
// Element-wise AdaGrad update, signed Q16.16 weights and gradients.
// Request channel: drive req and pulse start; busy is always low, so one
// request is taken every cycle that start is high.
// Result channel: done strobes for one cycle with res; the receiver cannot
// stall and must take every result in the cycle it appears.
// Config: cfg_we with cfg_index (0 learning rate, 1 epsilon) and cfg_data;
// write only while no request is in flight.
// Path from start to done, each step registered: the square and the
// accumulator sum, the square root (8 bits a stage), the divisor, the
// 47-bit division (7 quotient bits a stage) and the weight subtraction
// and saturation.
// Throughput: one request per cycle, set by the fully pipelined root and
// divider stages.
// Reset clears all stage valid bits, so no result is shown, and sets the
// learning rate to 655 and epsilon to 1.
module adagrad_weight_update (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  agu_pkg::in_t    req,
	output logic            done,
	output agu_pkg::out_t   res,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_index,
	input  logic [15:0]     cfg_data
);
	logic [15:0] lr_q, eps_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= agu_pkg::LrReset;
			eps_q <= agu_pkg::EpsReset;
		end else if (cfg_we) begin
			case (cfg_index)
				agu_pkg::RegLearningRate: lr_q  <= cfg_data;
				agu_pkg::RegEpsilon:      eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: magnitude, square and lr product
	logic        v_s1, neg_s1;
	logic [63:0] sq_s1;
	logic [46:0] num_s1;
	logic [31:0] acc_s1;
	logic signed [31:0] w_s1;
	logic        last_s1;
	logic [31:0] mag;

	assign mag = req.gradient[31] ? 32'(-req.gradient) : 32'(req.gradient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end
	always_ff @(posedge clk) begin
		neg_s1  <= req.gradient[31];
		sq_s1   <= 64'(mag) * 64'(mag);
		num_s1  <= 47'(48'(lr_q) * 48'(mag));
		acc_s1  <= req.accum_in;
		w_s1    <= req.weight_in;
		last_s1 <= req.is_last;
	end

	// stage 2: saturating accumulator sum
	logic           v_s2;
	logic [31:0]    sum_s2;
	agu_pkg::side_t sd_s2;
	logic [48:0]    sum_c;

	assign sum_c = 49'(sq_s1[63:16]) + 49'(acc_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		sum_s2       <= (sum_c[48:32] != '0) ? 32'hFFFF_FFFF : sum_c[31:0];
		sd_s2.neg    <= neg_s1;
		sd_s2.num    <= num_s1;
		sd_s2.weight <= w_s1;
		sd_s2.accum  <= sum_c[48:32] != '0 ? 32'hFFFF_FFFF : sum_c[31:0];
		sd_s2.last   <= last_s1;
	end

	// square root of the new accumulator
	logic           v_rt;
	logic [24:0]    root;
	agu_pkg::side_t sd_rt;

	agu_sqrt u_sqrt (
		.clk, .arst_n,
		.in_valid (v_s2),
		.radicand (sum_s2),
		.in_side  (sd_s2),
		.out_valid(v_rt),
		.root     (root),
		.out_side (sd_rt)
	);

	// divisor stage: root plus epsilon, zero forced to one
	logic           v_s3;
	logic [25:0]    d_s3;
	agu_pkg::side_t sd_s3;
	logic [25:0]    d_c;

	assign d_c = 26'(root) + 26'(eps_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_rt;
		end
	end
	always_ff @(posedge clk) begin
		d_s3  <= (d_c == '0) ? 26'd1 : d_c;
		sd_s3 <= sd_rt;
	end

	// step magnitude
	logic           v_dv;
	logic [46:0]    quot;
	agu_pkg::side_t sd_dv;

	agu_div u_div (
		.clk, .arst_n,
		.in_valid (v_s3),
		.divisor  (d_s3),
		.in_side  (sd_s3),
		.out_valid(v_dv),
		.quotient (quot),
		.out_side (sd_dv)
	);

	// weight update with saturation
	logic signed [48:0] nw;
	assign nw = sd_dv.neg ? 49'(sd_dv.weight) + signed'({2'b00, quot})
	                      : 49'(sd_dv.weight) - signed'({2'b00, quot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_dv;
		end
	end
	always_ff @(posedge clk) begin
		res.accum_out <= sd_dv.accum;
		res.last_out  <= sd_dv.last;
		if (nw > 49'sh0_7FFF_FFFF) begin
			res.weight_out <= 32'sh7FFF_FFFF;
		end else if (nw < -49'sh0_8000_0000) begin
			res.weight_out <= 32'sh8000_0000;
		end else begin
			res.weight_out <= nw[31:0];
		end
	end
endmodule

// ===== sv/agu_checker.sv =====
`timescale 1ns / 1ps
// port-level checks on the update block
module agu_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  logic            done,
	input  agu_pkg::out_t   res
);
	// block never refuses a request
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	// each request yields a result after fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start, 14) && $past(arst_n, 14) |-> done)
		else $error("missing result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(arst_n, 14) |-> $past(start, 14))
		else $error("unrequested result");
	// a shown result is fully defined
	a_res_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(res))
		else $error("undefined result");
endmodule

bind adagrad_weight_update agu_checker u_agu_checker (
	.clk, .arst_n, .start, .busy, .done, .res
);
